>>> src/pps_pkg.sv
// shared types and constants of the prime sieve
`default_nettype none
package pps_pkg;

    // width of the candidate and prime fields on the ports
    localparam int unsigned DATA_W = 16;

    // control broadcast from the sequencer to every cell of the row
    typedef struct packed {
        logic init;   // clear the running remainder
        logic shift;  // take one candidate bit, msb first
        logic din;    // the candidate bit
        logic wr;     // store the candidate in the cell at the fill count
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/pipelined_prime_sieve_top.sv
// prime sieve top level: stream ports, sequencer and output register
//
// usage
// - input beat on s_*: s_tdata carries the candidate, s_tlast empties the prime
//   store once that beat has been handled
// - result beat on m_*: m_tdata carries a candidate that no stored prime divides,
//   m_tuser flags that the store was full and the value was not kept
// - a zero candidate or one that a stored prime divides gives no result beat
// - one candidate is worked on at a time: bit-serial division in every cell at
//   once, then the hit flag ripples down the row of cells, then the decision;
//   a zero candidate skips the division and the ripple
// - a result beat shows in the cycle after the decision that emits it
// - the result sits in an output register, so the next candidate is taken and
//   worked on while the receiver stalls; only a decision that must emit waits
//   for that register to drain
// - reset empties the store and drops any pending result beat
`default_nettype none
module pipelined_prime_sieve_top #(
    parameter int unsigned MAX_PRIMES = 64,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] candidate
    input  wire logic        s_tlast,   // last candidate, empties the store
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] prime value
    output logic             m_tuser    // [0] store overflow
);

    localparam int unsigned DW    = pps_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(MAX_PRIMES + 1);
    localparam int unsigned BIT_W = $clog2(VALUE_BITS);
    localparam int unsigned RIP_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_RIPPLE = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  cand_reg, cand_next;
    logic [VALUE_BITS-1:0]  shift_reg, shift_next;
    logic                   last_reg, last_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [RIP_W-1:0]       rip_cnt_reg, rip_cnt_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [DW-1:0]          m_data_reg, m_data_next;
    logic                   m_ovf_reg, m_ovf_next;

    pps_pkg::cell_ctrl_t    ctrl;
    logic                   divided;
    logic                   s_accept;
    logic                   out_free;
    logic                   pass;
    logic                   full;
    logic [VALUE_BITS-1:0]  in_value;
    logic [DW+VALUE_BITS-1:0] in_ext;
    logic [DW+VALUE_BITS-1:0] out_ext;

    // candidate narrowed or widened to the working width
    assign in_ext   = {{VALUE_BITS{1'b0}}, s_tdata};
    assign in_value = in_ext[VALUE_BITS-1:0];
    assign out_ext  = {{DW{1'b0}}, cand_reg};

    assign s_tready = state_reg == ST_IDLE;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = count_reg == CNT_W'(MAX_PRIMES);
    assign pass     = (cand_reg != '0) && !divided;

    always_comb begin
        state_next   = state_reg;
        cand_next    = cand_reg;
        shift_next   = shift_reg;
        last_next    = last_reg;
        bit_cnt_next = bit_cnt_reg;
        rip_cnt_next = rip_cnt_reg;
        count_next   = count_reg;
        m_data_next  = m_data_reg;
        m_ovf_next   = m_ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ctrl         = '0;
        ctrl.din     = shift_reg[VALUE_BITS-1];

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cand_next    = in_value;
                    shift_next   = in_value;
                    last_next    = s_tlast;
                    bit_cnt_next = BIT_W'(VALUE_BITS - 1);
                    ctrl.init    = 1'b1;
                    // zero is dropped without a division
                    state_next   = (in_value == '0) ? ST_DECIDE : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                ctrl.shift = 1'b1;
                shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
                if (bit_cnt_reg == '0) begin
                    rip_cnt_next = RIP_W'(MAX_PRIMES - 1);
                    state_next   = ST_RIPPLE;
                end else begin
                    bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                end
            end
            ST_RIPPLE: begin
                // one cell per cycle until the flag leaves the last cell
                if (rip_cnt_reg == '0) begin
                    state_next = ST_DECIDE;
                end else begin
                    rip_cnt_next = rip_cnt_reg - RIP_W'(1);
                end
            end
            ST_DECIDE: begin
                if (!pass || out_free) begin
                    if (pass) begin
                        m_valid_next = 1'b1;
                        m_data_next  = out_ext[DW-1:0];
                        m_ovf_next   = full;
                        if (!full) begin
                            ctrl.wr    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    if (last_reg) begin
                        count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cand_reg    <= cand_next;
        shift_reg   <= shift_next;
        last_reg    <= last_next;
        bit_cnt_reg <= bit_cnt_next;
        rip_cnt_reg <= rip_cnt_next;
        m_data_reg  <= m_data_next;
        m_ovf_reg   <= m_ovf_next;
    end

    pps_chain #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_PRIMES (MAX_PRIMES),
        .CNT_W      (CNT_W)
    ) u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .wr_value (cand_reg),
        .count    (count_reg),
        .divided  (divided)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ovf_reg;

endmodule
`default_nettype wire

>>> src/pps_cell.sv
// one sieve cell: holds a prime, divides the candidate bit by bit, passes the hit flag on
`default_nettype none
module pps_cell #(
    parameter int unsigned VALUE_BITS = 16,
    parameter int unsigned CNT_W      = 7,
    parameter int unsigned INDEX      = 0
) (
    input  wire logic                   aclk,
    input  wire pps_pkg::cell_ctrl_t    ctrl,
    input  wire logic [VALUE_BITS-1:0]  wr_value,
    input  wire logic [CNT_W-1:0]       count,
    input  wire logic                   hit_in,
    output logic                        hit_out
);

    logic [VALUE_BITS-1:0] prime_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic                  used;
    logic                  selected;

    assign used     = count > CNT_W'(INDEX);
    assign selected = count == CNT_W'(INDEX);

    // restoring division step: bring in one bit, subtract the prime if it fits
    assign trial = {rem_reg, ctrl.din};
    assign diff  = trial - {1'b0, prime_reg};

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.init) begin
            rem_next = '0;
        end else if (ctrl.shift) begin
            if (trial >= {1'b0, prime_reg}) begin
                rem_next = diff[VALUE_BITS-1:0];
            end else begin
                rem_next = trial[VALUE_BITS-1:0];
            end
        end
    end

    assign hit_next = hit_in | (used & (rem_reg == '0));

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        hit_reg <= hit_next;
        if (ctrl.wr && selected) begin
            prime_reg <= wr_value;
        end
    end

    assign hit_out = hit_reg;

endmodule
`default_nettype wire

>>> src/pps_chain.sv
// row of sieve cells with the hit flag rippling from cell to cell
`default_nettype none
module pps_chain #(
    parameter int unsigned VALUE_BITS = 16,
    parameter int unsigned MAX_PRIMES = 64,
    parameter int unsigned CNT_W      = 7
) (
    input  wire logic                   aclk,
    input  wire pps_pkg::cell_ctrl_t    ctrl,
    input  wire logic [VALUE_BITS-1:0]  wr_value,
    input  wire logic [CNT_W-1:0]       count,
    output logic                        divided
);

    logic [MAX_PRIMES:0] hit_link;

    assign hit_link[0] = 1'b0;

    for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_cell
        pps_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .wr_value (wr_value),
            .count    (count),
            .hit_in   (hit_link[i]),
            .hit_out  (hit_link[i+1])
        );
    end

    assign divided = hit_link[MAX_PRIMES];

endmodule
`default_nettype wire
